@@ design/cfpp_pkg.sv @@
// shared constants, record type and tag decode for the class file pool parser
`timescale 1ns / 1ps
package cfpp_pkg;

    // record kinds
    localparam logic [2:0] KIND_MAGIC   = 3'd0;
    localparam logic [2:0] KIND_MINOR   = 3'd1;
    localparam logic [2:0] KIND_MAJOR   = 3'd2;
    localparam logic [2:0] KIND_COUNT   = 3'd3;
    localparam logic [2:0] KIND_FIELD   = 3'd4;
    localparam logic [2:0] KIND_UTF8B   = 3'd5;
    localparam logic [2:0] KIND_UTF8L   = 3'd6;
    localparam logic [2:0] KIND_UNKNOWN = 3'd7;

    // constant pool tags
    localparam logic [7:0] TAG_UTF8      = 8'd1;
    localparam logic [7:0] TAG_INTEGER   = 8'd3;
    localparam logic [7:0] TAG_FLOAT     = 8'd4;
    localparam logic [7:0] TAG_LONG      = 8'd5;
    localparam logic [7:0] TAG_DOUBLE    = 8'd6;
    localparam logic [7:0] TAG_CLASS     = 8'd7;
    localparam logic [7:0] TAG_STRING    = 8'd8;
    localparam logic [7:0] TAG_FIELDREF  = 8'd9;
    localparam logic [7:0] TAG_METHODREF = 8'd10;
    localparam logic [7:0] TAG_IMETHREF  = 8'd11;
    localparam logic [7:0] TAG_NAMETYPE  = 8'd12;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] index;
        logic [7:0]  tag;
        logic        fnum;
        logic [31:0] value;
        logic        done;
    } t_result;

    // bytes per field, 0 for an unknown tag
    function automatic logic [2:0] field_bytes(input logic [7:0] tag);
        logic [2:0] nb;
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_FIELDREF,
            TAG_METHODREF, TAG_IMETHREF, TAG_NAMETYPE: nb = 3'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE: nb = 3'd4;
            default: nb = 3'd0;
        endcase
        return nb;
    endfunction

    // entries with a second field
    function automatic logic has_two_fields(input logic [7:0] tag);
        logic two;
        case (tag)
            TAG_LONG, TAG_DOUBLE, TAG_FIELDREF,
            TAG_METHODREF, TAG_IMETHREF, TAG_NAMETYPE: two = 1'b1;
            default: two = 1'b0;
        endcase
        return two;
    endfunction

    // long and double take two slots
    function automatic logic is_wide(input logic [7:0] tag);
        return (tag == TAG_LONG) || (tag == TAG_DOUBLE);
    endfunction

endpackage

@@ design/class_file_pool_parser_unit.sv @@
// top level: byte-serial constant pool parser with output register and skid stage
// a record is registered into the output register, or into the skid stage while the output is stalled
// throughput: one byte per cycle; o_stall rises only while the skid stage holds a record
// the limit is the single per-byte state update feeding the result register
// reset: synchronous active-low i_rst_n clears parse state, output and skid valid
// i_restart with a byte restarts the parse at the magic number, that byte included
`timescale 1ns / 1ps
module class_file_pool_parser_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_restart,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [2:0]               o_item_kind,
    output logic [15:0]              o_entry_index,
    output logic [7:0]               o_entry_tag,
    output logic                     o_field_number,
    output logic [31:0]              o_value,
    output logic                     o_pool_done
);
    import cfpp_pkg::*;

    // parse phases, one-hot
    typedef enum logic [7:0] {
        PH_MAGIC = 8'b0000_0001,
        PH_MINOR = 8'b0000_0010,
        PH_MAJOR = 8'b0000_0100,
        PH_COUNT = 8'b0000_1000,
        PH_TAG   = 8'b0001_0000,
        PH_FIELD = 8'b0010_0000,
        PH_UTF8  = 8'b0100_0000,
        PH_DONE  = 8'b1000_0000
    } t_phase;

    // parse state
    t_phase      r_phase, n_phase, c_phase;
    logic [1:0]  r_pos, n_pos, c_pos;
    logic [31:0] r_acc, n_acc, c_acc;
    logic [15:0] r_entry, n_entry, c_entry;
    logic [15:0] r_pool, n_pool, c_pool;
    logic [7:0]  r_kind, n_kind, c_kind;
    logic        r_fsel, n_fsel, c_fsel;
    logic [15:0] r_utf, n_utf, c_utf;

    // output register and skid stage
    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;

    // per-byte result
    t_result     res;
    logic        res_valid;

    logic [31:0] acc_shift;
    logic [7:0]  kind_eff;
    logic [16:0] fin_next;
    logic        fin_done;
    logic        last_byte;

    logic        in_take;
    logic        out_take;

    assign in_take  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    // per-byte parse step
    always_comb begin
        // a restart byte sees the reset state
        c_phase = i_restart ? PH_MAGIC : r_phase;
        c_pos   = i_restart ? 2'd0     : r_pos;
        c_acc   = i_restart ? 32'd0    : r_acc;
        c_entry = i_restart ? 16'd0    : r_entry;
        c_pool  = i_restart ? 16'd0    : r_pool;
        c_kind  = i_restart ? 8'd0     : r_kind;
        c_fsel  = i_restart ? 1'b0     : r_fsel;
        c_utf   = i_restart ? 16'd0    : r_utf;

        n_phase = c_phase;
        n_pos   = c_pos;
        n_acc   = c_acc;
        n_entry = c_entry;
        n_pool  = c_pool;
        n_kind  = c_kind;
        n_fsel  = c_fsel;
        n_utf   = c_utf;

        res       = '0;
        res_valid = 1'b0;

        acc_shift = {c_acc[23:0], i_data_byte};
        last_byte = 1'b0;

        // closing an entry: the tag byte itself is the kind while in the tag phase
        kind_eff = (c_phase == PH_TAG) ? i_data_byte : c_kind;
        fin_next = {1'b0, c_entry} + (is_wide(kind_eff) ? 17'd2 : 17'd1);
        fin_done = (fin_next >= {1'b0, c_pool});

        case (c_phase)
            PH_MAGIC, PH_MINOR, PH_MAJOR, PH_COUNT: begin
                last_byte = (c_phase == PH_MAGIC) ? (c_pos == 2'd3) : (c_pos == 2'd1);
                if (!last_byte) begin
                    n_acc = acc_shift;
                    n_pos = c_pos + 2'd1;
                end else begin
                    n_acc      = '0;
                    n_pos      = '0;
                    res_valid  = 1'b1;
                    res.value  = acc_shift;
                    case (c_phase)
                        PH_MAGIC: begin
                            res.kind = KIND_MAGIC;
                            n_phase  = PH_MINOR;
                        end
                        PH_MINOR: begin
                            res.kind = KIND_MINOR;
                            n_phase  = PH_MAJOR;
                        end
                        PH_MAJOR: begin
                            res.kind = KIND_MAJOR;
                            n_phase  = PH_COUNT;
                        end
                        default: begin
                            // pool count; zero or one means an empty pool
                            res.kind = KIND_COUNT;
                            n_pool   = acc_shift[15:0];
                            n_entry  = 16'd1;
                            if (acc_shift[15:1] == 15'd0) begin
                                n_phase  = PH_DONE;
                                res.done = 1'b1;
                            end else begin
                                n_phase  = PH_TAG;
                            end
                        end
                    endcase
                end
            end

            PH_TAG: begin
                n_kind = i_data_byte;
                n_fsel = 1'b0;
                n_pos  = '0;
                n_acc  = '0;
                if (field_bytes(i_data_byte) != 3'd0) begin
                    n_phase = PH_FIELD;
                end else begin
                    // unknown tag: one record, slot advances by one
                    res_valid = 1'b1;
                    res.kind  = KIND_UNKNOWN;
                    res.index = c_entry;
                    res.tag   = i_data_byte;
                    res.done  = fin_done;
                    if (fin_done) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_entry = fin_next[15:0];
                        n_phase = PH_TAG;
                    end
                end
            end

            PH_FIELD: begin
                last_byte = (field_bytes(c_kind) == 3'd4) ? (c_pos == 2'd3) : (c_pos == 2'd1);
                if (!last_byte) begin
                    n_acc = acc_shift;
                    n_pos = c_pos + 2'd1;
                end else begin
                    n_acc     = '0;
                    n_pos     = '0;
                    res_valid = 1'b1;
                    res.index = c_entry;
                    res.value = acc_shift;
                    if (c_kind == TAG_UTF8) begin
                        res.kind = KIND_UTF8L;
                        res.tag  = TAG_UTF8;
                        n_utf    = acc_shift[15:0];
                        if (acc_shift[15:0] == 16'd0) begin
                            // empty string ends the entry here
                            res.done = fin_done;
                            n_fsel   = 1'b0;
                            if (fin_done) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_entry = fin_next[15:0];
                                n_phase = PH_TAG;
                            end
                        end else begin
                            n_phase = PH_UTF8;
                        end
                    end else begin
                        res.kind = KIND_FIELD;
                        res.tag  = c_kind;
                        res.fnum = c_fsel;
                        if (!c_fsel && has_two_fields(c_kind)) begin
                            n_fsel = 1'b1;
                        end else begin
                            res.done = fin_done;
                            n_fsel   = 1'b0;
                            if (fin_done) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_entry = fin_next[15:0];
                                n_phase = PH_TAG;
                            end
                        end
                    end
                end
            end

            PH_UTF8: begin
                // payload bytes pass straight through
                n_utf      = c_utf - 16'd1;
                res_valid  = 1'b1;
                res.kind   = KIND_UTF8B;
                res.index  = c_entry;
                res.tag    = TAG_UTF8;
                res.value  = {24'd0, i_data_byte};
                if (n_utf == 16'd0) begin
                    res.done = fin_done;
                    n_pos    = '0;
                    n_acc    = '0;
                    n_fsel   = 1'b0;
                    if (fin_done) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_entry = fin_next[15:0];
                        n_phase = PH_TAG;
                    end
                end
            end

            PH_DONE: begin
                // bytes after the pool are dropped
                res_valid = 1'b0;
            end

            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // parse state registers, advanced once per accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MAGIC;
            r_pos   <= '0;
            r_acc   <= '0;
            r_entry <= '0;
            r_pool  <= '0;
            r_kind  <= '0;
            r_fsel  <= 1'b0;
            r_utf   <= '0;
        end else if (in_take) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_entry <= n_entry;
            r_pool  <= n_pool;
            r_kind  <= n_kind;
            r_fsel  <= n_fsel;
            r_utf   <= n_utf;
        end
    end

    // output register with skid stage so input keeps flowing while the output is stalled and the skid stage is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_take && res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_take && res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_stall        = r_skid_valid;
    assign o_valid        = r_out_valid;
    assign o_item_kind    = r_out.kind;
    assign o_entry_index  = r_out.index;
    assign o_entry_tag    = r_out.tag;
    assign o_field_number = r_out.fnum;
    assign o_value        = r_out.value;
    assign o_pool_done    = r_out.done;

endmodule

@@ design/cfpp_checker.sv @@
// port-level checker for the class file pool parser, bound to the top level
`timescale 1ns / 1ps
module cfpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_item_kind,
    input logic [15:0] o_entry_index,
    input logic [7:0]  o_entry_tag,
    input logic        o_field_number,
    input logic [31:0] o_value,
    input logic        o_pool_done
);
    import cfpp_pkg::*;

    // a stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item_kind) && $stable(o_entry_index)
            && $stable(o_entry_tag) && $stable(o_field_number) && $stable(o_value)
            && $stable(o_pool_done))
        else $error("output transaction changed under stall");

    // reset empties both output stages
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output not empty after reset");

    // header records carry no slot and no tag
    a_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == KIND_MAGIC || o_item_kind == KIND_MINOR
            || o_item_kind == KIND_MAJOR || o_item_kind == KIND_COUNT)
        |-> o_entry_index == 16'd0 && o_entry_tag == 8'd0 && !o_field_number)
        else $error("header record with entry slot or tag");

    // second field only on plain entry fields
    a_field_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_field_number |-> o_item_kind == KIND_FIELD)
        else $error("second field flag on a non-field record");

    // utf8 records belong to a utf8 entry
    a_utf8_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_kind == KIND_UTF8B || o_item_kind == KIND_UTF8L)
        |-> o_entry_tag == TAG_UTF8 && o_entry_index != 16'd0)
        else $error("utf8 record with wrong tag or slot");

endmodule

bind class_file_pool_parser_unit cfpp_checker u_cfpp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_item_kind    (o_item_kind),
    .o_entry_index  (o_entry_index),
    .o_entry_tag    (o_entry_tag),
    .o_field_number (o_field_number),
    .o_value        (o_value),
    .o_pool_done    (o_pool_done)
);

@@ tb/class_file_pool_parser_unit_tb.sv @@
// self-checking testbench for the class file constant pool parser
`timescale 1ns / 1ps

module class_file_pool_parser_unit_tb;

    import cfpp_pkg::*;

    localparam int ITEM_TARGET = 1800;

    // receiver stall styles, each kept for a random run before the next is picked
    typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_style;

    // bytes per field of a pool entry, 0 when the tag is not a known one
    function automatic int field_width(input logic [7:0] tag);
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_FIELDREF,
            TAG_METHODREF, TAG_IMETHREF, TAG_NAMETYPE: return 2;
            TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE: return 4;
            default: return 0;
        endcase
    endfunction

    // entries that carry a second field
    function automatic bit two_fields(input logic [7:0] tag);
        case (tag)
            TAG_LONG, TAG_DOUBLE, TAG_FIELDREF,
            TAG_METHODREF, TAG_IMETHREF, TAG_NAMETYPE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // tracks the parse of the byte stream and checks the emitted records in order
    class pool_scoreboard;
        typedef enum logic [2:0] {
            ST_MAGIC, ST_MINOR, ST_MAJOR, ST_COUNT, ST_TAG, ST_FIELD, ST_UTF8, ST_DONE
        } t_parse_state;

        t_parse_state state;
        logic [1:0]   pos;
        logic [31:0]  acc;
        logic [15:0]  slot;
        logic [15:0]  slot_count;
        logic [7:0]   tag;
        logic         second;
        logic [15:0]  utf8_left;

        t_result records_due[$];
        int      errors;

        function new();
            errors = 0;
            restart_parse();
        endfunction

        function void restart_parse();
            state      = ST_MAGIC;
            pos        = '0;
            acc        = '0;
            slot       = '0;
            slot_count = '0;
            tag        = '0;
            second     = 1'b0;
            utf8_left  = '0;
        endfunction

        // end of the current entry: advance the slot, or finish the pool
        function void close_entry(output logic pool_end);
            int nxt;
            nxt    = int'(slot) + (((tag == TAG_LONG) || (tag == TAG_DOUBLE)) ? 2 : 1);
            pos    = '0;
            acc    = '0;
            second = 1'b0;
            if (nxt >= int'(slot_count)) begin
                state    = ST_DONE;
                pool_end = 1'b1;
            end else begin
                slot     = nxt[15:0];
                state    = ST_TAG;
                pool_end = 1'b0;
            end
        endfunction

        // one accepted byte: update the parse and queue the record it completes
        function void note_input(input logic [7:0] b, input logic rs);
            t_result     r;
            logic        pool_end;
            logic [31:0] word;
            int          nb;
            bit          emits;
            r     = '0;
            emits = 1'b0;
            if (rs)
                restart_parse();
            case (state)
                ST_MAGIC, ST_MINOR, ST_MAJOR, ST_COUNT: begin
                    nb  = (state == ST_MAGIC) ? 4 : 2;
                    acc = {acc[23:0], b};
                    if (int'(pos) + 1 < nb) begin
                        pos = pos + 2'd1;
                    end else begin
                        word    = acc;
                        pos     = '0;
                        acc     = '0;
                        emits   = 1'b1;
                        r.value = word;
                        case (state)
                            ST_MAGIC: begin
                                r.kind = KIND_MAGIC;
                                state  = ST_MINOR;
                            end
                            ST_MINOR: begin
                                r.kind = KIND_MINOR;
                                state  = ST_MAJOR;
                            end
                            ST_MAJOR: begin
                                r.kind = KIND_MAJOR;
                                state  = ST_COUNT;
                            end
                            default: begin
                                r.kind     = KIND_COUNT;
                                slot_count = word[15:0];
                                slot       = 16'd1;
                                if (slot_count <= 16'd1) begin
                                    state  = ST_DONE;
                                    r.done = 1'b1;
                                end else begin
                                    state = ST_TAG;
                                end
                            end
                        endcase
                    end
                end
                ST_TAG: begin
                    tag    = b;
                    second = 1'b0;
                    pos    = '0;
                    acc    = '0;
                    if (field_width(b) != 0) begin
                        state = ST_FIELD;
                    end else begin
                        emits   = 1'b1;
                        r.kind  = KIND_UNKNOWN;
                        r.index = slot;
                        r.tag   = b;
                        close_entry(pool_end);
                        r.done  = pool_end;
                    end
                end
                ST_FIELD: begin
                    nb  = field_width(tag);
                    acc = {acc[23:0], b};
                    if (int'(pos) + 1 < nb) begin
                        pos = pos + 2'd1;
                    end else begin
                        word    = acc;
                        pos     = '0;
                        acc     = '0;
                        emits   = 1'b1;
                        r.index = slot;
                        r.tag   = tag;
                        r.value = word;
                        if (tag == TAG_UTF8) begin
                            r.kind    = KIND_UTF8L;
                            utf8_left = word[15:0];
                            if (utf8_left == 16'd0) begin
                                close_entry(pool_end);
                                r.done = pool_end;
                            end else begin
                                state = ST_UTF8;
                            end
                        end else begin
                            r.kind = KIND_FIELD;
                            r.fnum = second;
                            if (!second && two_fields(tag)) begin
                                second = 1'b1;
                            end else begin
                                close_entry(pool_end);
                                r.done = pool_end;
                            end
                        end
                    end
                end
                ST_UTF8: begin
                    emits     = 1'b1;
                    r.kind    = KIND_UTF8B;
                    r.index   = slot;
                    r.tag     = TAG_UTF8;
                    r.value   = {24'd0, b};
                    utf8_left = utf8_left - 16'd1;
                    if (utf8_left == 16'd0) begin
                        close_entry(pool_end);
                        r.done = pool_end;
                    end
                end
                default: ;
            endcase
            if (emits)
                records_due.push_back(r);
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(input t_result got);
            t_result want;
            if (records_due.size() == 0) begin
                report($sformatf("unexpected record kind %0d idx %0d tag %0d value %h",
                                 got.kind, got.index, got.tag, got.value));
                return;
            end
            want = records_due.pop_front();
            if (got !== want)
                report($sformatf({"got kind %0d idx %0d tag %0d fnum %0b value %h done %0b,",
                                  " want kind %0d idx %0d tag %0d fnum %0b value %h done %0b"},
                                 got.kind, got.index, got.tag, got.fnum, got.value, got.done,
                                 want.kind, want.index, want.tag, want.fnum, want.value,
                                 want.done));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_restart;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_item_kind;
    logic [15:0] o_entry_index;
    logic [7:0]  o_entry_tag;
    logic        o_field_number;
    logic [31:0] o_value;
    logic        o_pool_done;

    pool_scoreboard sb = new();

    // whole byte stream, {restart, data byte} per transaction
    logic [8:0] stream_q[$];
    int         stream_items;

    class_file_pool_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_item_kind    (o_item_kind),
        .o_entry_index  (o_entry_index),
        .o_entry_tag    (o_entry_tag),
        .o_field_number (o_field_number),
        .o_value        (o_value),
        .o_pool_done    (o_pool_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // stream construction
    // ---------------------------------------------------------------

    task automatic put_u2(ref logic [7:0] f[$], input logic [15:0] v);
        f.push_back(v[15:8]);
        f.push_back(v[7:0]);
    endtask

    task automatic put_u4(ref logic [7:0] f[$], input logic [31:0] v);
        put_u2(f, v[31:16]);
        put_u2(f, v[15:0]);
    endtask

    // a file goes out with restart on its first byte; these all count as items
    task automatic queue_file(ref logic [7:0] f[$]);
        foreach (f[i])
            stream_q.push_back({(i == 0), f[i]});
        stream_items += f.size();
    endtask

    // random bytes after a file, not counted; the block drops them only once the pool is done
    task automatic queue_tail(input int n);
        repeat (n)
            stream_q.push_back({1'b0, 8'($urandom)});
    endtask

    // mostly known tags with utf8 weighted up, some unknown ones
    function automatic logic [7:0] random_tag();
        logic [7:0] t;
        case ($urandom_range(0, 15))
            0:       t = TAG_UTF8;
            1:       t = TAG_INTEGER;
            2:       t = TAG_FLOAT;
            3:       t = TAG_LONG;
            4:       t = TAG_DOUBLE;
            5:       t = TAG_CLASS;
            6:       t = TAG_STRING;
            7:       t = TAG_FIELDREF;
            8:       t = TAG_METHODREF;
            9:       t = TAG_IMETHREF;
            10:      t = TAG_NAMETYPE;
            11, 12:  t = TAG_UTF8;
            default: begin
                do t = 8'($urandom); while (field_width(t) != 0);
            end
        endcase
        return t;
    endfunction

    // directed files: header extremes, a pool count of one, unknown tag,
    // empty string and a double that overruns the last slot
    task automatic add_directed();
        logic [7:0] f[$];
        put_u4(f, 32'hFFFF_FFFF);
        put_u2(f, 16'h0000);
        put_u2(f, 16'hFFFF);
        put_u2(f, 16'h0001);
        queue_file(f);
        queue_tail(1);
        f.delete();
        put_u4(f, 32'hCAFE_BABE);
        put_u2(f, 16'h0003);
        put_u2(f, 16'h0034);
        put_u2(f, 16'h0004);
        f.push_back(8'hFF);
        f.push_back(TAG_UTF8);
        put_u2(f, 16'h0000);
        f.push_back(TAG_DOUBLE);
        put_u4(f, 32'h0123_4567);
        put_u4(f, 32'h89AB_CDEF);
        queue_file(f);
        queue_tail(2);
    endtask

    // one well-formed file with random content, sometimes cut short,
    // or now and then plain noise with stray restarts
    task automatic add_random_file();
        logic [7:0] f[$];
        logic [7:0] tg;
        int         count, slot, len, cut;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                stream_q.push_back({(i == 0) || ($urandom_range(0, 7) == 0), 8'($urandom)});
            stream_items += len;
            return;
        end
        put_u4(f, ($urandom_range(0, 7) == 0) ? $urandom : 32'hCAFE_BABE);
        put_u2(f, 16'($urandom));
        put_u2(f, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(45, 65)));
        case ($urandom_range(0, 19))
            0:       count = 0;
            1:       count = 1;
            2:       count = 16'hFFFF;
            default: count = $urandom_range(2, 16);
        endcase
        put_u2(f, 16'(count));
        slot = 1;
        // a huge count is only walked for a couple dozen slots
        while (slot < count && slot <= 24) begin
            tg = random_tag();
            f.push_back(tg);
            if (tg == TAG_UTF8) begin
                if ($urandom_range(0, 49) == 0)
                    len = $urandom_range(100, 300);
                else if ($urandom_range(0, 4) == 0)
                    len = 0;
                else
                    len = $urandom_range(1, 10);
                put_u2(f, 16'(len));
                repeat (len) f.push_back(8'($urandom));
            end else if (field_width(tg) != 0) begin
                repeat ((two_fields(tg) ? 2 : 1) * field_width(tg))
                    f.push_back(8'($urandom));
            end
            slot += ((tg == TAG_LONG) || (tg == TAG_DOUBLE)) ? 2 : 1;
        end
        // broken file: the next restart lands mid-parse
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, f.size());
            while (f.size() > cut) void'(f.pop_back());
        end
        queue_file(f);
        queue_tail($urandom_range(0, 3));
    endtask

    // ---------------------------------------------------------------
    // input channel driver
    // ---------------------------------------------------------------

    // holds the transaction until it is taken at a rising edge without stall
    task automatic send_byte(input logic [8:0] t);
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_restart   = t[8];
        i_data_byte = t[7:0];
        do @(posedge i_clk); while (o_stall);
        sb.note_input(t[7:0], t[8]);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // bursts of random length; a quarter of them run straight into the next
    task automatic drive_stream();
        int idx, burst;
        idx = 0;
        while (idx < stream_q.size()) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && idx < stream_q.size()) begin
                send_byte(stream_q[idx]);
                idx++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        idle_cycles(1);
    endtask

    // ---------------------------------------------------------------
    // output channel: stall pattern and record monitor
    // ---------------------------------------------------------------

    initial begin : rx_pattern
        t_rx_style style;
        int        left, run;
        i_stall = 1'b0;
        style   = RX_FLOW;
        left    = 0;
        run     = 0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                style = t_rx_style'($urandom_range(0, 3));
                left  = $urandom_range(32, 256);
            end
            left--;
            case (style)
                RX_FLOW:  i_stall = 1'b0;
                RX_LIGHT: i_stall = ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_stall = ($urandom_range(0, 3) != 0);
                default:  i_stall = ((left % 5) < 2);
            endcase
            // break up long runs of stall by forcing i_stall low
            if (i_stall)
                run++;
            else
                run = 0;
            if (run > 6) begin
                i_stall = 1'b0;
                run     = 0;
            end
        end
    end

    // a record transaction completes at a rising edge with valid and no stall
    always @(posedge i_clk) begin : record_monitor
        t_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.kind  = o_item_kind;
            got.index = o_entry_index;
            got.tag   = o_entry_tag;
            got.fnum  = o_field_number;
            got.value = o_value;
            got.done  = o_pool_done;
            sb.check_result(got);
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = 8'h00;
        i_restart    = 1'b0;
        stream_items = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_directed();
        while (stream_items < ITEM_TARGET)
            add_random_file();
        drive_stream();

        // drain outstanding records, then give the skid stage time to misbehave
        while (sb.records_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0)
            $display("class_file_pool_parser_unit verification clean");
        else
            $display("class_file_pool_parser_unit verification failed");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("class_file_pool_parser_unit verification failed");
        $finish;
    end

endmodule
